// File: sv/page_frame_free_list_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page frame free list allocator
// Concurrent assertion forms used by the allocator datapath.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define PFFLA_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("allocator invariant violated");

// The consequence holds in the same cycle as the antecedent.
`define PFFLA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator implication violated");

// The consequence holds in the cycle after the antecedent.
`define PFFLA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator sequence violated");

`endif

// File: sv/pffla_pkg.sv
// ----------------------------------------------------------------------------
// Page frame free list allocator package
// Payload types, field widths, codes and controller interface structs.
// ----------------------------------------------------------------------------
package pffla_pkg;

   localparam int POOL_PAGES_DEFAULT = 128;

   localparam int TYPE_W  = 1;
   localparam int COUNT_W = 8;
   localparam int INDEX_W = 7;
   localparam int FRAME_W = 20;
   localparam int LEFT_W  = 8;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef struct packed {
      logic [TYPE_W-1:0]  req_type;
      logic [COUNT_W-1:0] page_count;
      logic [INDEX_W-1:0] chain_index;
   } req_item_type;

   typedef struct packed {
      logic               status;
      logic [INDEX_W-1:0] first_index;
      logic [FRAME_W-1:0] first_frame;
      logic [LEFT_W-1:0]  free_left;
   } rsp_item_type;

   typedef struct packed {
      logic init_wr;
      logic capture;
      logic issue;
      logic walk;
      logic post_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic init_last;
      logic refuse_now;
      logic walk_end;
      logic out_free;
   } dp_status_type;

endpackage

// File: sv/pffla_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pffla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pffla_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences the initialization pass, request checks, link walks and result loading.
// ----------------------------------------------------------------------------
module pffla_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pffla_pkg::dp_status_type status,
   output pffla_pkg::ctl_cmd_type   cmd
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_POST  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (status.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.issue = 1'b1;
            state_in  = status.refuse_now ? ST_POST : ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_end) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            cmd.post_load = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: sv/pffla_datapath.sv
// ----------------------------------------------------------------------------
// Allocator datapath
// Holds the free list state, the link store and the result register.
// ----------------------------------------------------------------------------
`include "page_frame_free_list_allocator_unit_assert.svh"

module pffla_datapath #(
   parameter int POOL_PAGES = pffla_pkg::POOL_PAGES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pffla_pkg::req_item_type            req_item,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pffla_pkg::rsp_item_type            rsp_item,
   input  logic                               csr_wr_en,
   input  logic [pffla_pkg::FRAME_W-1:0]      csr_wr_data,
   input  pffla_pkg::ctl_cmd_type             cmd,
   output pffla_pkg::dp_status_type           status
);

   localparam int IDX_W = $clog2(POOL_PAGES);
   localparam int LNK_W = $clog2(POOL_PAGES + 1);
   localparam int CNT_W = $clog2(POOL_PAGES + 1);
   localparam logic [LNK_W-1:0] LINK_NULL = LNK_W'(POOL_PAGES);
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(POOL_PAGES);
   localparam logic [IDX_W-1:0] INDEX_LAST = IDX_W'(POOL_PAGES - 1);

   pffla_pkg::req_item_type req_ff, req_in;
   pffla_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        cur_ff, cur_in;
   logic [CNT_W-1:0]        step_ff, step_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic                    empty_ff, empty_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [pffla_pkg::FRAME_W-1:0] base_ff, base_in;
   logic                    res_status_ff, res_status_in;
   logic [IDX_W-1:0]        res_first_ff, res_first_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [LNK_W-1:0] wr_data;
   logic [IDX_W-1:0] rd_addr;
   logic [LNK_W-1:0] rd_data;

   logic             nx_null;
   logic [IDX_W-1:0] nx_idx;
   logic [CNT_W-1:0] len;
   logic [CNT_W:0]   sum;
   logic [31:0]      page32;
   logic [31:0]      count32;
   logic [31:0]      chain32;
   logic [31:0]      first32;
   logic [31:0]      req_chain32;
   logic [CNT_W-1:0] n_cnt;
   logic [IDX_W-1:0] start_idx;
   logic [IDX_W-1:0] req_idx;
   logic             refuse_now;

   pffla_ram #(
      .WIDTH (LNK_W),
      .DEPTH (POOL_PAGES)
   ) u_link_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      nx_null     = (rd_data >= LINK_NULL);
      nx_idx      = rd_data[IDX_W-1:0];
      len         = step_ff + CNT_W'(1);
      sum         = {1'b0, count_ff} + {1'b0, len};
      page32      = 32'(req_ff.page_count);
      count32     = 32'(count_ff);
      chain32     = 32'(req_item.chain_index);
      req_chain32 = 32'(req_ff.chain_index);
      first32     = 32'(res_first_ff);
      n_cnt       = page32[CNT_W-1:0];
      start_idx   = chain32[IDX_W-1:0];
      req_idx     = req_chain32[IDX_W-1:0];
      if (req_ff.req_type == pffla_pkg::REQ_ALLOC) begin
         refuse_now = (page32 == 32'd0) || empty_ff || (page32 > count32);
      end else begin
         refuse_now = (req_chain32 >= 32'(POOL_PAGES));
      end
   end

   always_comb begin
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      cur_in        = cur_ff;
      step_in       = step_ff;
      head_in       = head_ff;
      empty_in      = empty_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = LINK_NULL;
      rd_addr       = cmd.walk ? nx_idx : cur_ff;
      status        = '0;

      if (csr_wr_en) begin
         base_in = csr_wr_data;
      end

      if (cmd.init_wr) begin
         wr_en            = 1'b1;
         wr_data          = LNK_W'(cur_ff) + LNK_W'(1);
         cur_in           = cur_ff + IDX_W'(1);
         status.init_last = (cur_ff == INDEX_LAST);
      end

      if (cmd.capture) begin
         req_in = req_item;
         cur_in = (req_item.req_type == pffla_pkg::REQ_ALLOC) ? head_ff : start_idx;
      end

      if (cmd.issue) begin
         status.refuse_now = refuse_now;
         step_in           = '0;
         if (refuse_now) begin
            res_status_in = pffla_pkg::STATUS_REFUSED;
            res_first_in  = '0;
         end
      end

      if (cmd.walk) begin
         if (req_ff.req_type == pffla_pkg::REQ_ALLOC) begin
            if (len == n_cnt) begin
               status.walk_end = 1'b1;
               wr_en           = 1'b1;
               wr_data         = LINK_NULL;
               if (nx_null) begin
                  empty_in = 1'b1;
                  head_in  = '0;
               end else begin
                  head_in = nx_idx;
               end
               count_in      = count_ff - n_cnt;
               res_status_in = pffla_pkg::STATUS_DONE;
               res_first_in  = head_ff;
            end else if (nx_null) begin
               status.walk_end = 1'b1;
               res_status_in   = pffla_pkg::STATUS_REFUSED;
               res_first_in    = '0;
            end else begin
               cur_in  = nx_idx;
               step_in = len;
            end
         end else begin
            if (nx_null) begin
               status.walk_end = 1'b1;
               wr_en           = !empty_ff;
               wr_data         = LNK_W'(head_ff);
               head_in         = req_idx;
               empty_in        = 1'b0;
               count_in        = (sum > (CNT_W+1)'(POOL_PAGES)) ? COUNT_FULL : sum[CNT_W-1:0];
               res_status_in   = pffla_pkg::STATUS_DONE;
               res_first_in    = '0;
            end else if (len == COUNT_FULL) begin
               status.walk_end = 1'b1;
               res_status_in   = pffla_pkg::STATUS_REFUSED;
               res_first_in    = '0;
            end else begin
               cur_in  = nx_idx;
               step_in = len;
            end
         end
      end

      status.out_free = !rsp_valid_ff || !rsp_stall;
      if (cmd.post_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = res_status_ff;
         rsp_in.first_index = first32[pffla_pkg::INDEX_W-1:0];
         if (res_status_ff == pffla_pkg::STATUS_DONE &&
             req_ff.req_type == pffla_pkg::REQ_ALLOC) begin
            rsp_in.first_frame = base_ff + first32[pffla_pkg::FRAME_W-1:0];
         end else begin
            rsp_in.first_frame = '0;
         end
         rsp_in.free_left   = count32[pffla_pkg::LEFT_W-1:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         head_ff      <= '0;
         empty_ff     <= 1'b0;
         count_ff     <= COUNT_FULL;
         base_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         head_ff      <= head_in;
         empty_ff     <= empty_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
      end
      req_ff        <= req_in;
      rsp_ff        <= rsp_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `PFFLA_ASSERT_ALWAYS(a_count_bound, clock, reset, 32'(count_ff) <= 32'(POOL_PAGES))
   `PFFLA_ASSERT_ALWAYS(a_head_in_pool, clock, reset, 32'(head_ff) < 32'(POOL_PAGES))
   `PFFLA_ASSERT_IMPLY(a_load_when_free, clock, reset, cmd.post_load, !rsp_valid_ff || !rsp_stall)
   `PFFLA_ASSERT_NEXT(a_init_stops, clock, reset, cmd.init_wr && status.init_last, !cmd.init_wr)

endmodule

// File: sv/page_frame_free_list_allocator_unit.sv
// ----------------------------------------------------------------------------
// Page frame free list allocator
// After reset the link store is initialized while requests are stalled. Each
// accepted request is then checked, its chain is walked and its result is
// loaded. An allocate request of n pages walks n links and a free request of
// a chain of L pages walks L links; the chain is followed one link per cycle
// through the single read port of the link store. A refused request that
// fails its first check skips the walk. One request is in flight at a time,
// and a finished result waits in the output register while the next request
// is accepted.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator_unit #(
   parameter int POOL_PAGES = pffla_pkg::POOL_PAGES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pffla_pkg::req_item_type       req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pffla_pkg::rsp_item_type       rsp_item,
   input  logic                          csr_wr_en,
   input  logic [pffla_pkg::FRAME_W-1:0] csr_wr_data
);

   pffla_pkg::ctl_cmd_type   cmd;
   pffla_pkg::dp_status_type status;

   pffla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pffla_datapath #(
      .POOL_PAGES (POOL_PAGES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
